### hdl/pvb_pkg.sv
// pvb_pkg: shared types and constants for the pyramid voxel backprojection core
// no dependencies
package pvb_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic [1:0] PLANE_LEFT = 2'd0;
	localparam logic [1:0] PLANE_BACK = 2'd3;

	localparam logic [2:0] REG_VOXEL_X = 3'd0;
	localparam logic [2:0] REG_VOXEL_Y = 3'd1;
	localparam logic [2:0] REG_VOXEL_Z = 3'd2;
	localparam logic [2:0] REG_INIT_COEF = 3'd3;

	localparam int ACC_W = 48;

	// one finished event handed from front to back
	typedef struct packed {
		logic [31:0] weight;
		logic        hit;
		logic        last;
		logic        load;
		logic [31:0] init;
	} evt_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_ADD
	} bk_state_t;

endpackage

### hdl/pvb_queue.sv
// pvb_queue: small register fifo of finished events between front and back
// depends on pvb_pkg
module pvb_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  pvb_pkg::evt_t               push_data,
	input  logic                        pop,
	output pvb_pkg::evt_t               pop_data,
	output logic                        not_empty,
	output logic [pvb_pkg::QCNT_W-1:0]  count
);

	localparam int QCNT_W = pvb_pkg::QCNT_W;

	pvb_pkg::evt_t                    mem_q [pvb_pkg::QDEPTH];
	logic [pvb_pkg::QPTR_W-1:0]       wr_q;
	logic [pvb_pkg::QPTR_W-1:0]       rd_q;
	logic [pvb_pkg::QCNT_W-1:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign pop_data  = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

endmodule

### hdl/pvb_front.sv
// pvb_front: plane test per item, inside flag per event, run start tracking
// depends on pvb_pkg
module pvb_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [31:0]                 plane_a,
	input  logic [31:0]                 plane_b,
	input  logic [31:0]                 plane_c,
	input  logic [31:0]                 plane_d,
	input  logic [1:0]                  plane_index,
	input  logic [31:0]                 event_weight,
	input  logic                        last_event,
	input  logic [15:0]                 voxel_x,
	input  logic [15:0]                 voxel_y,
	input  logic [15:0]                 voxel_z,
	input  logic [31:0]                 initial_coefficient,
	input  logic [pvb_pkg::QCNT_W-1:0]  q_count,
	output logic                        push,
	output pvb_pkg::evt_t               push_data
);

	localparam int PW = 32 + COORD_BITS;
	localparam int VW = PW + 2;

	logic signed [COORD_BITS-1:0] x_c, y_c, z_c;
	logic signed [PW-1:0]         pa_s1, pb_s1, pc_s1;
	logic signed [31:0]           d_s1;
	logic [1:0]                   idx_s1;
	logic [31:0]                  w_s1;
	logic                         last_s1, load_s1, v_s1;
	logic [31:0]                  init_s1;
	logic                         ins_q, run_q, pend_q;
	logic [31:0]                  init_q;
	logic signed [VW-1:0]         val;
	logic                         cur_inside;
	logic                         acc;

	assign x_c = voxel_x[COORD_BITS-1:0];
	assign y_c = voxel_y[COORD_BITS-1:0];
	assign z_c = voxel_z[COORD_BITS-1:0];

	// queue must hold every back item already in flight
	assign in_ready = (pvb_pkg::QCNT_W'(q_count) + pvb_pkg::QCNT_W'(v_s1))
		< pvb_pkg::QCNT_W'(pvb_pkg::QDEPTH);
	assign acc = in_valid & in_ready;

	always_ff @(posedge clk) begin
		if (acc) begin
			pa_s1   <= PW'($signed(plane_a)) * PW'(x_c);
			pb_s1   <= PW'($signed(plane_b)) * PW'(y_c);
			pc_s1   <= PW'($signed(plane_c)) * PW'(z_c);
			d_s1    <= $signed(plane_d);
			idx_s1  <= plane_index;
			w_s1    <= event_weight;
			last_s1 <= last_event;
			load_s1 <= !run_q | pend_q;
			init_s1 <= run_q ? init_q : initial_coefficient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			run_q  <= 1'b0;
			pend_q <= 1'b0;
			init_q <= '0;
		end else begin
			v_s1 <= acc;
			if (acc) begin
				if (plane_index == pvb_pkg::PLANE_BACK) begin
					pend_q <= 1'b0;
					run_q  <= !last_event;
				end else if (!run_q) begin
					run_q  <= 1'b1;
					pend_q <= 1'b1;
					init_q <= initial_coefficient;
				end
			end
		end
	end

	assign val = VW'(pa_s1) + VW'(pb_s1) + VW'(pc_s1) - VW'(d_s1);
	assign cur_inside = ((idx_s1 == pvb_pkg::PLANE_LEFT) ? 1'b1 : ins_q) & (val <= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_q <= 1'b1;
		end else if (v_s1) begin
			ins_q <= (idx_s1 == pvb_pkg::PLANE_BACK) ? 1'b1 : cur_inside;
		end
	end

	assign push = v_s1 & (idx_s1 == pvb_pkg::PLANE_BACK);
	always_comb begin
		push_data.weight = w_s1;
		push_data.hit    = cur_inside;
		push_data.last   = last_s1;
		push_data.load   = load_s1;
		push_data.init   = init_s1;
	end

endmodule

### hdl/pvb_back.sv
// pvb_back: reciprocal by bit-serial division and saturating accumulate
// depends on pvb_pkg
module pvb_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  pvb_pkg::evt_t               q_data,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pvb_pkg::ACC_W-1:0]   out_coef,
	output logic                        out_inside,
	output logic                        out_last
);

	localparam int NW = 2 * FRAC_BITS + 1;
	localparam int CW = $clog2(NW);
	localparam int SW = pvb_pkg::ACC_W + 3;
	localparam logic signed [SW-1:0] ACC_MAX = SW'({1'b0, {(pvb_pkg::ACC_W-1){1'b1}}});
	localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX - SW'(1);

	pvb_pkg::bk_state_t st_q, st_nx;

	logic signed [pvb_pkg::ACC_W-1:0] acc_q;
	logic [32:0]         den_q;
	logic [33:0]         rem_q;
	logic [NW-1:0]       quo_q;
	logic [CW-1:0]       cnt_q;
	logic                neg_q, add_q, inside_q, last_q;
	logic                ov_q;
	logic [pvb_pkg::ACC_W-1:0] coef_q;
	logic                oins_q, olast_q;

	logic signed [32:0]  w_ext;
	logic [32:0]         w_mag;
	logic [33:0]         rem_sh;
	logic                fit;
	logic                do_add;
	logic                out_free;
	logic signed [SW-1:0] recip, sum, sat;

	assign w_ext = {q_data.weight[31], q_data.weight};
	assign w_mag = q_data.weight[31] ? 33'(-w_ext) : 33'(w_ext);

	// dividend is a single one at the top bit
	assign rem_sh = {rem_q[32:0], (cnt_q == CW'(NW - 1))};
	assign fit    = rem_sh >= {1'b0, den_q};

	assign out_free = !ov_q | out_ready;

	always_comb begin
		st_nx = st_q;
		case (st_q)
			pvb_pkg::BK_IDLE: begin
				if (q_valid) begin
					st_nx = (q_data.hit && q_data.weight != '0) ?
						pvb_pkg::BK_DIV : pvb_pkg::BK_ADD;
				end
			end
			pvb_pkg::BK_DIV: begin
				if (cnt_q == '0) begin
					st_nx = pvb_pkg::BK_ADD;
				end
			end
			pvb_pkg::BK_ADD: begin
				if (out_free) begin
					st_nx = pvb_pkg::BK_IDLE;
				end
			end
			default: st_nx = pvb_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = 1'b0;
		do_add = 1'b0;
		case (st_q)
			pvb_pkg::BK_IDLE: q_pop  = q_valid;
			pvb_pkg::BK_ADD:  do_add = out_free;
			default: begin
				q_pop  = 1'b0;
				do_add = 1'b0;
			end
		endcase
	end

	assign recip = neg_q ? -SW'(quo_q) : SW'(quo_q);
	assign sum   = SW'(acc_q) + (add_q ? recip : SW'(0));
	assign sat   = (sum > ACC_MAX) ? ACC_MAX : ((sum < ACC_MIN) ? ACC_MIN : sum);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			den_q    <= w_mag;
			neg_q    <= q_data.weight[31];
			add_q    <= q_data.hit && q_data.weight != '0;
			inside_q <= q_data.hit;
			last_q   <= q_data.last;
			rem_q    <= '0;
			quo_q    <= '0;
			cnt_q    <= CW'(NW - 1);
		end else if (st_q == pvb_pkg::BK_DIV) begin
			rem_q <= fit ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[NW-2:0], fit};
			cnt_q <= cnt_q - 1'b1;
		end
		if (do_add) begin
			coef_q  <= sat[pvb_pkg::ACC_W-1:0];
			oins_q  <= inside_q;
			olast_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= pvb_pkg::BK_IDLE;
			acc_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (q_pop && q_data.load) begin
				acc_q <= pvb_pkg::ACC_W'($signed(q_data.init));
			end else if (do_add) begin
				acc_q <= sat[pvb_pkg::ACC_W-1:0];
			end
			if (do_add) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid  = ov_q;
	assign out_coef   = coef_q;
	assign out_inside = oins_q;
	assign out_last   = olast_q;

endmodule

### hdl/pyramid_voxel_backprojection_core.sv
// flow: a back plane item is queued in the cycle after it is accepted; the back end
// pops it in IDLE, runs the 33-step serial divider in DIV when a reciprocal is added,
// and in ADD writes the output register once that is free; throughput: one plane item
// per cycle while the 4-entry event queue has room; one event at a time in the back end
// reset: arst_n clears config, run state, accumulator, queue, output valid; inside flag to one
module pyramid_voxel_backprojection_core #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// plane_a, plane_b, plane_c, plane_d, event_weight
	input  logic [159:0] s_axis_tdata,
	// plane_index
	input  logic [1:0]   s_axis_tuser,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// coefficient, event_inside, zero pad
	output logic [55:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [15:0] vx_q, vy_q, vz_q;
	logic [31:0] init_q;

	logic                       push, pop, q_ne;
	pvb_pkg::evt_t              push_data, pop_data;
	logic [pvb_pkg::QCNT_W-1:0] q_count;
	logic [pvb_pkg::ACC_W-1:0]  coef;
	logic                       ins;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q   <= '0;
			vy_q   <= '0;
			vz_q   <= '0;
			init_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pvb_pkg::REG_VOXEL_X:   vx_q   <= cfg_data[15:0];
				pvb_pkg::REG_VOXEL_Y:   vy_q   <= cfg_data[15:0];
				pvb_pkg::REG_VOXEL_Z:   vz_q   <= cfg_data[15:0];
				pvb_pkg::REG_INIT_COEF: init_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pvb_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (s_axis_tvalid),
		.in_ready            (s_axis_tready),
		.plane_a             (s_axis_tdata[31:0]),
		.plane_b             (s_axis_tdata[63:32]),
		.plane_c             (s_axis_tdata[95:64]),
		.plane_d             (s_axis_tdata[127:96]),
		.plane_index         (s_axis_tuser),
		.event_weight        (s_axis_tdata[159:128]),
		.last_event          (s_axis_tlast),
		.voxel_x             (vx_q),
		.voxel_y             (vy_q),
		.voxel_z             (vz_q),
		.initial_coefficient (init_q),
		.q_count             (q_count),
		.push                (push),
		.push_data           (push_data)
	);

	pvb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_ne),
		.count     (q_count)
	);

	pvb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_ne),
		.q_data     (pop_data),
		.q_pop      (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_coef   (coef),
		.out_inside (ins),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, ins, coef};

`ifndef SYNTHESIS
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= pvb_pkg::QCNT_W'(pvb_pkg::QDEPTH))
		else $error("event queue count beyond depth");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_count == pvb_pkg::QCNT_W'(pvb_pkg::QDEPTH) |-> !s_axis_tready)
		else $error("input taken with event queue full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_ne)
		else $error("pop from empty event queue");
`endif

endmodule

### sim/pyramid_voxel_backprojection_core_tb.sv
// self-checking testbench for pyramid_voxel_backprojection_core: plane beats in,
// coefficient beats out, checked against an in-bench event predictor
// depends on hdl/pvb_pkg.sv and hdl/pyramid_voxel_backprojection_core.sv
`timescale 1ns / 1ps

module pyramid_voxel_backprojection_core_tb;

	localparam logic [1:0] PLANE_LEFT = pvb_pkg::PLANE_LEFT;
	localparam logic [1:0] PLANE_RIGHT = 2'd1;
	localparam logic [1:0] PLANE_FRONT = 2'd2;
	localparam logic [1:0] PLANE_BACK = pvb_pkg::PLANE_BACK;
	localparam logic [2:0] REG_VOXEL_X = pvb_pkg::REG_VOXEL_X;
	localparam logic [2:0] REG_VOXEL_Y = pvb_pkg::REG_VOXEL_Y;
	localparam logic [2:0] REG_VOXEL_Z = pvb_pkg::REG_VOXEL_Z;
	localparam logic [2:0] REG_INIT_COEF = pvb_pkg::REG_INIT_COEF;
	localparam logic [2:0] REG_NONE = 3'd5;
	localparam longint COEF_MAX = 64'sh00007FFFFFFFFFFF;
	localparam longint COEF_MIN = -COEF_MAX - 1;

	typedef struct {
		logic [31:0] a, b, c, d;
		logic [1:0]  idx;
		logic [31:0] w;
		logic        last;
		bit          typed;
		logic [47:0] coef;
		logic        hit;
	} plane_item_t;

	typedef struct {
		logic [47:0] coef;
		logic        hit;
		logic        last;
	} coef_beat_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [55:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	pyramid_voxel_backprojection_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] vox_x, vox_y, vox_z;
	logic [31:0] init_coef;
	bit          in_flag;
	longint      coef_acc;
	bit          run_on;

	coef_beat_t  coef_q[$];
	plane_item_t dir_tab[$];
	int          errors, mismatches, items_sent, beats_seen, inside_seen;
	bit          idle_on;
	int          rx_stall;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#20ms;
		$display("timeout waiting for coefficient beats");
		$display("pyramid_voxel_backprojection_core_tb: FAIL");
		$finish;
	end

	// folds one accepted plane beat into the event state
	task automatic fold_plane(input plane_item_t it);
		longint val, recip, sum;
		coef_beat_t r;
		if (!run_on) begin
			coef_acc = longint'($signed(init_coef));
			run_on = 1;
		end
		val = longint'($signed(it.a)) * longint'($signed(vox_x))
			+ longint'($signed(it.b)) * longint'($signed(vox_y))
			+ longint'($signed(it.c)) * longint'($signed(vox_z))
			- longint'($signed(it.d));
		if (it.idx == PLANE_LEFT)
			in_flag = 1;
		in_flag = in_flag && (val <= 0);
		if (it.idx != PLANE_BACK)
			return;
		if (in_flag && it.w != 0) begin
			recip = (64'sd1 <<< 32) / longint'($signed(it.w));
			sum = coef_acc + recip;
			if (sum > COEF_MAX)
				sum = COEF_MAX;
			if (sum < COEF_MIN)
				sum = COEF_MIN;
			coef_acc = sum;
		end
		r.coef = coef_acc[47:0];
		r.hit = in_flag;
		r.last = it.last;
		if (it.typed) begin
			r.coef = it.coef;
			r.hit = it.hit;
		end
		coef_q.push_back(r);
		in_flag = 1;
		if (it.last)
			run_on = 0;
	endtask

	task automatic send_plane(input plane_item_t it);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {it.w, it.d, it.c, it.b, it.a};
		s_axis_tuser <= it.idx;
		s_axis_tlast <= it.last;
		do @(posedge clk); while (!s_axis_tready);
		fold_plane(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_VOXEL_X: vox_x = val[15:0];
			REG_VOXEL_Y: vox_y = val[15:0];
			REG_VOXEL_Z: vox_z = val[15:0];
			REG_INIT_COEF: init_coef = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (coef_q.size() != 0)
			@(negedge clk);
		// trailing plane beats with no result may still be in the pipe
		repeat (60) @(negedge clk);
	endtask

	task automatic add_row(input logic [1:0] idx, input logic [31:0] a, b, c, d, w,
			input logic last, input bit typed, input logic [47:0] coef, input logic hit);
		plane_item_t it;
		it.a = a; it.b = b; it.c = c; it.d = d; it.idx = idx; it.w = w; it.last = last;
		it.typed = typed; it.coef = coef; it.hit = hit;
		dir_tab.push_back(it);
	endtask

	// mostly planes that put the voxel on the inner side, with some full-range noise
	function automatic plane_item_t rand_plane(input logic [1:0] idx, input logic last);
		plane_item_t it;
		longint dot;
		it.idx = idx;
		it.last = last;
		it.typed = 0;
		it.coef = '0;
		it.hit = 0;
		case ($urandom_range(0, 5))
			0: it.w = '0;
			1: it.w = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'hFFFF_FFFF;
			2: it.w = $urandom_range(1, 200);
			3: it.w = 32'h0001_0000 + $urandom_range(0, 32'h0004_0000);
			default: it.w = $urandom;
		endcase
		if ($urandom_range(0, 9) < 7) begin
			it.a = $urandom_range(0, 4000) - 2000;
			it.b = $urandom_range(0, 4000) - 2000;
			it.c = $urandom_range(0, 4000) - 2000;
			dot = longint'($signed(it.a)) * longint'($signed(vox_x))
				+ longint'($signed(it.b)) * longint'($signed(vox_y))
				+ longint'($signed(it.c)) * longint'($signed(vox_z));
			dot = dot + $urandom_range(0, 600) - 60;
			if (dot > 64'sh7FFFFFFF || dot < -64'sh80000000)
				it.d = $urandom;
			else
				it.d = dot[31:0];
		end else begin
			it.a = $urandom;
			it.b = $urandom;
			it.c = $urandom;
			it.d = $urandom;
		end
		return it;
	endfunction

	always @(posedge clk) begin
		coef_beat_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_seen++;
			if (m_axis_tdata[48])
				inside_seen++;
			if (coef_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected beat: coef=%h inside=%b last=%b",
						m_axis_tdata[47:0], m_axis_tdata[48], m_axis_tlast);
			end else begin
				e = coef_q.pop_front();
				if (m_axis_tdata[47:0] !== e.coef || m_axis_tdata[48] !== e.hit
						|| m_axis_tlast !== e.last) begin
					errors++;
					if (mismatches++ < 10)
						$display("beat %0d: exp coef=%h inside=%b last=%b, got %h %b %b",
							beats_seen, e.coef, e.hit, e.last,
							m_axis_tdata[47:0], m_axis_tdata[48], m_axis_tlast);
				end
			end
		end
	end

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_stall <= $urandom_range(0, 10);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		int n;
		logic [1:0] order[4];
		plane_item_t it;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_VOXEL_X;
		cfg_data = '0;
		rx_stall = 0;
		idle_on = 1;
		errors = 0; mismatches = 0; items_sent = 0; beats_seen = 0; inside_seen = 0;
		vox_x = '0; vox_y = '0; vox_z = '0; init_coef = '0;
		in_flag = 1; coef_acc = 0; run_on = 0;
		order = '{PLANE_LEFT, PLANE_RIGHT, PLANE_FRONT, PLANE_BACK};

		// voxel at origin, start coefficient zero: plane value is just -d
		add_row(PLANE_LEFT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(PLANE_RIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(PLANE_FRONT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(PLANE_BACK, 0, 0, 0, 0, 32'h0001_0000, 0, 1, 48'h0000_0001_0000, 1);
		// outside on the left plane, nothing added
		add_row(PLANE_LEFT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			0, 0, 0, 0, 0);
		add_row(PLANE_RIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(PLANE_FRONT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(PLANE_BACK, 0, 0, 0, 0, 32'h0000_0001, 0, 1, 48'h0000_0001_0000, 0);
		// outside on the left plane with zero weight, closes the run
		add_row(PLANE_LEFT, 0, 0, 0, 32'h8000_0000, 0, 1, 0, 0, 0);
		add_row(PLANE_RIGHT, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(PLANE_FRONT, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(PLANE_BACK, 0, 0, 0, 0, 32'h0000_0000, 1, 1, 48'h0000_0001_0000, 0);
		// new run restarts from zero, weight of -1 lsb
		add_row(PLANE_LEFT, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(PLANE_RIGHT, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(PLANE_FRONT, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(PLANE_BACK, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 48'hFFFF_0000_0000, 1);
		// no left plane, most negative weight
		add_row(PLANE_RIGHT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
		add_row(PLANE_FRONT, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
		add_row(PLANE_BACK, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
		// shuffled order, largest weight
		add_row(PLANE_FRONT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			0, 0, 0, 0, 0);
		add_row(PLANE_RIGHT, 0, 0, 0, 32'h0000_0001, 0, 0, 0, 0, 0);
		add_row(PLANE_BACK, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, 0, 0, 0);
		// lone left item left pending across a register phase
		add_row(PLANE_LEFT, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_plane(dir_tab[i]);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_VOXEL_X, 32'h0000_7FFF);
					write_reg(REG_VOXEL_Y, 32'h0000_8000);
					write_reg(REG_VOXEL_Z, 32'hFFFF_FFFF);
					write_reg(REG_INIT_COEF, 32'h7FFF_FFFF);
				end
				1: begin
					write_reg(REG_VOXEL_X, 32'h0000_8000);
					write_reg(REG_VOXEL_Y, 32'h0000_7FFF);
					write_reg(REG_VOXEL_Z, 32'h0000_8000);
					write_reg(REG_INIT_COEF, 32'h8000_0000);
				end
				default: begin
					write_reg(REG_VOXEL_X, $urandom);
					write_reg(REG_VOXEL_Y, $urandom);
					write_reg(REG_VOXEL_Z, $urandom);
					write_reg(REG_INIT_COEF, $urandom);
				end
			endcase
			write_reg(REG_NONE, $urandom);
			if (ph == 5)
				idle_on = 0;
			n = items_sent + 180;
			while (items_sent < n) begin
				if ($urandom_range(0, 9) < 8) begin
					// well-formed event, occasionally closing the run
					it.last = ($urandom_range(0, 9) == 0);
					for (int k = 0; k < 4; k++)
						send_plane(rand_plane(order[k],
							k == 3 ? it.last : 1'($urandom_range(0, 1))));
				end else begin
					send_plane(rand_plane(2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1))));
				end
			end
			drain();
		end

		$display("sent %0d plane beats over 7 register settings, checked %0d coefficient beats",
			items_sent, beats_seen);
		$display("%0d events inside, %0d mismatches", inside_seen, errors);
		if (errors == 0 && coef_q.size() == 0)
			$display("pyramid_voxel_backprojection_core_tb: PASS");
		else
			$display("pyramid_voxel_backprojection_core_tb: FAIL");
		$finish;
	end

endmodule
